// ===== hdl/assert_macros.svh =====
// assertion macros used by the multiplicative_weights_update rtl
// no dependencies; the caller supplies clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define MWU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define MWU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/mwu_pkg.sv =====
// constants and widths for the multiplicative weights update block
// no dependencies
`timescale 1ns / 1ps

package mwu_pkg;

  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned KEEP_W   = 16;
  localparam int unsigned PROD_W   = WEIGHT_W + KEEP_W;
  localparam int unsigned FC_W     = 8;
  localparam int unsigned PROB_W   = 17;
  localparam int unsigned XIDX_W   = 3;

  localparam logic [WEIGHT_W-1:0] ONE_Q31    = 32'h8000_0000;
  localparam logic [KEEP_W-1:0]   KEEP_RESET = 16'd58982;

endpackage

// ===== hdl/mwu_weight_mem.sv =====
// weight store: synchronous memory, one write and one registered read port
// uses mwu_pkg; entries never written read as one (Q1.31)
`timescale 1ns / 1ps

module mwu_weight_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [mwu_pkg::WEIGHT_W-1:0] wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [mwu_pkg::WEIGHT_W-1:0] rdata_o
);
  import mwu_pkg::*;

  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    vld_q;
  logic [WEIGHT_W-1:0] rd_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // per-entry valid bits stand in for the reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : ONE_Q31;

endmodule

// ===== hdl/mwu_divider.sv =====
// restoring divider for (weight << 16) / sum, one quotient bit per cycle
// uses mwu_pkg; quotient fits PROB_W bits because weight <= sum
`timescale 1ns / 1ps

module mwu_divider #(
  parameter int unsigned SUM_W = 35
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mwu_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [SUM_W-1:0]             divisor_i,
  output logic                         done_o,
  output logic [mwu_pkg::PROB_W-1:0]   quot_o
);
  import mwu_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROB_W);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    rem_q;
  logic [SUM_W-1:0]    rem_d;
  logic [SUM_W-1:0]    div_q;
  logic [PROB_W-1:0]   bits_q;
  logic [PROB_W-1:0]   quot_q;
  logic [SUM_W:0]      trial;
  logic                ge;

  assign trial = {rem_q, bits_q[PROB_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    if (ge) begin
      rem_d = SUM_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROB_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // the top 31 dividend bits (weight >> 1) are already below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= SUM_W'(weight_i[WEIGHT_W-1:1]);
      bits_q <= {weight_i[0], {(PROB_W-1){1'b0}}};
      quot_q <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      bits_q <= {bits_q[PROB_W-2:0], 1'b0};
      quot_q <= {quot_q[PROB_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/multiplicative_weights_update.sv =====
// Multiplicative weights update over NUM_EXPERTS experts.
// Input channel (in_valid_i/in_ready_o) carries one round: forecasts_i and
// outcome_i. Output channel (out_valid_o/out_ready_i) returns NUM_EXPERTS
// transfers per round in index order: expert_index_o, weight_out_o (Q1.31),
// probability_o (Q1.16) and last_o on the final one.
// One round is worked at a time; in_ready_o is high only while idle.
// Update pass per expert: memory read, 32x16 multiply, then write back and
// sum. Output pass per expert: memory read, then the bit-serial divider (17
// steps), then the output register.
// A stall on out_ready_i holds the output register and the sequencer.
// keep_factor_we_i writes keep_factor_i at once; write it only while idle.
// Reset sets all weights to one through per-entry valid bits (no clearing
// pass) and keep_factor to 58982.
// uses mwu_pkg, mwu_weight_mem, mwu_divider, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multiplicative_weights_update #(
  parameter int unsigned NUM_EXPERTS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         keep_factor_we_i,
  input  logic [mwu_pkg::KEEP_W-1:0]   keep_factor_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mwu_pkg::FC_W-1:0]     forecasts_i,
  input  logic                         outcome_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mwu_pkg::XIDX_W-1:0]   expert_index_o,
  output logic [mwu_pkg::WEIGHT_W-1:0] weight_out_o,
  output logic [mwu_pkg::PROB_W-1:0]   probability_o,
  output logic                         last_o
);
  import mwu_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_EXPERTS);
  localparam int unsigned SUM_W = WEIGHT_W + IDX_W;
  localparam int unsigned EXT_W = 7;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UPD_RD  = 8'b0000_0010,
    S_UPD_MUL = 8'b0000_0100,
    S_UPD_WR  = 8'b0000_1000,
    S_OUT_RD  = 8'b0001_0000,
    S_OUT_LD  = 8'b0010_0000,
    S_OUT_DIV = 8'b0100_0000,
    S_OUT_EMT = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [KEEP_W-1:0]   keep_q;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [FC_W-1:0]     fc_q, fc_d;
  logic                oc_q, oc_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic                wrong_q, wrong_d;
  logic [WEIGHT_W-1:0] wold_q, wold_d;
  logic                out_valid_q, out_valid_d;
  logic [XIDX_W-1:0]   xidx_q, xidx_d;
  logic [WEIGHT_W-1:0] wout_q, wout_d;
  logic [PROB_W-1:0]   prob_q, prob_d;
  logic                last_q, last_d;

  logic [EXT_W-1:0]    idx_ext;
  logic                guess;
  logic                is_last;
  logic [WEIGHT_W-1:0] scaled;
  logic [WEIGHT_W-1:0] w_new;
  logic                mem_we;
  logic [WEIGHT_W-1:0] mem_rdata;
  logic                div_start;
  logic                div_done;
  logic [PROB_W-1:0]   div_quot;

  assign idx_ext = EXT_W'(idx_q);
  // experts past the forecast field always forecast zero
  assign guess   = (idx_ext < EXT_W'(FC_W)) ? fc_q[idx_ext[XIDX_W-1:0]] : 1'b0;
  assign is_last = idx_q == IDX_W'(NUM_EXPERTS - 1);
  assign scaled  = (prod_q[PROD_W-1:KEEP_W] == '0) ? WEIGHT_W'(1)
                                                   : prod_q[PROD_W-1:KEEP_W];
  assign w_new   = wrong_q ? scaled : wold_q;
  assign mem_we  = state_q == S_UPD_WR;

  mwu_weight_mem #(
    .DEPTH (NUM_EXPERTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (w_new),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  mwu_divider #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .weight_i  (mem_rdata),
    .divisor_i (sum_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    fc_d        = fc_q;
    oc_d        = oc_q;
    prod_d      = prod_q;
    wrong_d     = wrong_q;
    wold_d      = wold_q;
    out_valid_d = out_valid_q;
    xidx_d      = xidx_q;
    wout_d      = wout_q;
    prob_d      = prob_q;
    last_d      = last_q;
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          fc_d    = forecasts_i;
          oc_d    = outcome_i;
          sum_d   = '0;
          idx_d   = '0;
          state_d = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        state_d = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        prod_d  = PROD_W'(mem_rdata) * PROD_W'(keep_q);
        wrong_d = guess != oc_q;
        wold_d  = mem_rdata;
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        sum_d = sum_q + SUM_W'(w_new);
        if (is_last) begin
          idx_d   = '0;
          state_d = S_OUT_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_UPD_RD;
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        div_start = 1'b1;
        wold_d    = mem_rdata;
        state_d   = S_OUT_DIV;
      end
      S_OUT_DIV: begin
        if (div_done) begin
          xidx_d      = idx_ext[XIDX_W-1:0];
          wout_d      = wold_q;
          prob_d      = div_quot;
          last_d      = is_last;
          out_valid_d = 1'b1;
          state_d     = S_OUT_EMT;
        end
      end
      S_OUT_EMT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      keep_q      <= KEEP_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (keep_factor_we_i) begin
        keep_q <= keep_factor_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    fc_q    <= fc_d;
    oc_q    <= oc_d;
    prod_q  <= prod_d;
    wrong_q <= wrong_d;
    wold_q  <= wold_d;
    xidx_q  <= xidx_d;
    wout_q  <= wout_d;
    prob_q  <= prob_d;
    last_q  <= last_d;
  end

  assign in_ready_o     = state_q == S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign expert_index_o = xidx_q;
  assign weight_out_o   = wout_q;
  assign probability_o  = prob_q;
  assign last_o         = last_q;

  `MWU_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "round overlap")
  `MWU_ASSERT(a_sum_nonzero, (state_q == S_OUT_LD) |-> (sum_q != '0), "zero weight sum")
  `MWU_ASSERT(a_div_in_place, div_done |-> (state_q == S_OUT_DIV), "stray divider done")
  `MWU_ASSERT(a_prob_range, out_valid_o |-> (probability_o <= 17'd65536), "probability > one")

endmodule

// ===== test/tb_top.sv =====
// testbench for multiplicative_weights_update: rounds of forecasts are sent in,
// the per-expert weight and probability transfers are checked against a local model
// depends on mwu_pkg and the multiplicative_weights_update rtl
`timescale 1ns / 1ps

module tb_top;
  import mwu_pkg::*;

  localparam int unsigned NUM_EXPERTS   = 8;
  localparam int unsigned ROUND_CYCLES  = 24 * NUM_EXPERTS + 8;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned ROUNDS_PER_SET = 75;

  typedef struct packed {
    logic [FC_W-1:0] fc;
    logic            oc;
  } round_t;

  typedef struct packed {
    logic [XIDX_W-1:0]   idx;
    logic [WEIGHT_W-1:0] weight;
    logic [PROB_W-1:0]   prob;
    logic                is_last;
  } expert_result_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                keep_factor_we_i = 1'b0;
  logic [KEEP_W-1:0]   keep_factor_i    = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [FC_W-1:0]     forecasts_i      = '0;
  logic                outcome_i        = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [XIDX_W-1:0]   expert_index_o;
  logic [WEIGHT_W-1:0] weight_out_o;
  logic [PROB_W-1:0]   probability_o;
  logic                last_o;

  round_t         pending_rounds[$];
  expert_result_t expected_results[$];
  logic [WEIGHT_W-1:0] model_weights[NUM_EXPERTS];
  logic [KEEP_W-1:0]   model_keep;

  int unsigned rounds_offered = 0;
  int unsigned rounds_taken   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned errors         = 0;

  multiplicative_weights_update #(
    .NUM_EXPERTS(NUM_EXPERTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .keep_factor_we_i(keep_factor_we_i),
    .keep_factor_i   (keep_factor_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .forecasts_i     (forecasts_i),
    .outcome_i       (outcome_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .expert_index_o  (expert_index_o),
    .weight_out_o    (weight_out_o),
    .probability_o   (probability_o),
    .last_o          (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // update the weights for one round and queue the per-expert results
  function automatic void update_weights(input logic [FC_W-1:0] fc, input logic oc);
    logic [PROD_W-1:0]   prod;
    logic [WEIGHT_W-1:0] scaled;
    logic [63:0]         total;
    logic [63:0]         quotient;
    expert_result_t      res;
    total = '0;
    for (int i = 0; i < NUM_EXPERTS; i++) begin
      if (fc[i] != oc) begin
        prod   = model_weights[i] * model_keep;
        scaled = prod[PROD_W-1:KEEP_W];
        model_weights[i] = (scaled == '0) ? WEIGHT_W'(1) : scaled;
      end
      total += model_weights[i];
    end
    for (int i = 0; i < NUM_EXPERTS; i++) begin
      quotient    = ({32'd0, model_weights[i]} << 16) / total;
      res.idx     = XIDX_W'(i);
      res.weight  = model_weights[i];
      res.prob    = quotient[PROB_W-1:0];
      res.is_last = (i == NUM_EXPERTS - 1);
      expected_results.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // driver: new payload only when the previous transfer has gone through
  always @(negedge clk_i) begin : drive_p
    logic   valid_next;
    round_t next_round;
    valid_next = in_valid_i && (rounds_offered != rounds_taken);
    if (!valid_next && pending_rounds.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      next_round   = pending_rounds.pop_front();
      forecasts_i <= next_round.fc;
      outcome_i   <= next_round.oc;
      rounds_offered++;
      valid_next = 1'b1;
    end
    in_valid_i  <= valid_next;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : monitor_p
    expert_result_t want;
    logic           moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        update_weights(forecasts_i, outcome_i);
        rounds_taken++;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result for expert %0d", expert_index_o));
        end else begin
          want = expected_results.pop_front();
          if (expert_index_o != want.idx)
            report_mismatch($sformatf("expert_index %0d, want %0d", expert_index_o, want.idx));
          if (weight_out_o != want.weight)
            report_mismatch($sformatf("expert %0d weight %0d, want %0d",
                                      want.idx, weight_out_o, want.weight));
          if (probability_o != want.prob)
            report_mismatch($sformatf("expert %0d probability %0d, want %0d",
                                      want.idx, probability_o, want.prob));
          if (last_o != want.is_last)
            report_mismatch($sformatf("expert %0d last %0b, want %0b",
                                      want.idx, last_o, want.is_last));
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_round(input logic [FC_W-1:0] fc, input logic oc);
    round_t r;
    r.fc = fc;
    r.oc = oc;
    pending_rounds.push_back(r);
  endtask

  // mostly experts with a fixed accuracy each, some fully random rounds
  task automatic queue_random_round();
    round_t r;
    r.oc = 1'($urandom_range(1));
    if ($urandom_range(9) < 3) begin
      r.fc = FC_W'($urandom_range(255));
    end else begin
      for (int i = 0; i < FC_W; i++)
        r.fc[i] = ($urandom_range(99) < 40 + 8 * i) ? r.oc : !r.oc;
    end
    pending_rounds.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_rounds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    keep_factor_we_i <= 1'b1;
    keep_factor_i    <= value;
    @(negedge clk_i);
    keep_factor_we_i <= 1'b0;
    model_keep = value;
  endtask

  initial begin
    logic [KEEP_W-1:0] set_keep[6];
    for (int i = 0; i < NUM_EXPERTS; i++) model_weights[i] = ONE_Q31;
    model_keep = KEEP_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rounds at the reset keep factor
    send_idle_pct = 19;
    recv_idle_pct = 77;
    queue_round(8'h00, 1'b0);
    queue_round(8'hFF, 1'b1);
    queue_round(8'hFF, 1'b0);
    queue_round(8'h00, 1'b1);
    queue_round(8'hAA, 1'b1);
    queue_round(8'h55, 1'b1);
    queue_round(8'h01, 1'b0);
    queue_round(8'h80, 1'b1);
    queue_round(8'h7F, 1'b0);
    queue_round(8'hFE, 1'b1);

    // largest keep factor
    write_keep(16'hFFFF);
    queue_round(8'hF0, 1'b1);
    queue_round(8'h0F, 1'b1);
    queue_round(8'hC3, 1'b0);

    // zero keep factor drops wrong experts to the floor, twice to hold there
    write_keep(16'h0000);
    queue_round(8'hFC, 1'b1);
    queue_round(8'hFC, 1'b1);
    queue_round(8'h3F, 1'b0);

    set_keep[0] = 16'hFFFF;
    set_keep[1] = KEEP_W'($urandom_range(60000, 65535));
    set_keep[2] = KEEP_RESET;
    set_keep[3] = KEEP_W'($urandom_range(0, 65535));
    set_keep[4] = 16'h8000;
    set_keep[5] = 16'h0001;
    for (int s = 0; s < 6; s++) begin
      write_keep(set_keep[s]);
      case (s / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ROUNDS_PER_SET; n++) queue_random_round();
    end

    wait_idle();
    repeat (ROUND_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
